### hw/rtl/tkh_pkg.sv
// Shared types and constants for the top-K min-heap selector.
`timescale 1ns / 1ps

package tkh_pkg;

    localparam int KEY_W = 32;
    localparam int ACT_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_OFFER = 2'd1,
        ACT_DRAIN = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_ROOT_RD,
        ST_ROOT_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DR_RD,
        ST_DR_LD
    } state_t;

endpackage

### hw/rtl/tkh_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module tkh_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 10,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### hw/rtl/tkh_engine.sv
// Heap engine: clear, sift-up insert, root replace with sift-down, and drain sequencing.
`timescale 1ns / 1ps

module tkh_engine #(
    parameter int HEAP_DEPTH = 10,
    parameter int TAG_BITS   = 10,
    localparam int SLOT_W  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1,
    localparam int CNT_W   = $clog2(HEAP_DEPTH + 1),
    localparam int CHILD_W = SLOT_W + 2,
    localparam int ENTRY_W = tkh_pkg::KEY_W + TAG_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tkh_pkg::action_t          in_action,
    input  logic [tkh_pkg::KEY_W-1:0] in_key,
    input  logic [TAG_BITS-1:0]       in_tag,
    input  logic                      out_free,
    output logic                      out_load,
    output logic [tkh_pkg::KEY_W-1:0] out_key,
    output logic [TAG_BITS-1:0]       out_tag,
    output logic [SLOT_W-1:0]         out_slot,
    output logic                      out_last
);

    tkh_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [SLOT_W-1:0]         pos_reg, pos_next;
    logic [tkh_pkg::KEY_W-1:0] cur_key_reg, cur_key_next;
    logic [TAG_BITS-1:0]       cur_tag_reg, cur_tag_next;

    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [SLOT_W-1:0]  rd_addr_a, rd_addr_b;
    logic [ENTRY_W-1:0] rd_data_a, rd_data_b;

    logic [SLOT_W-1:0]         parent;
    logic [CHILD_W-1:0]        left_idx, right_idx;
    logic                      left_in, right_in;
    logic [tkh_pkg::KEY_W-1:0] key_a, key_b, best_key;
    logic                      pick_left, pick_right;
    logic                      drain_last;

    tkh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign parent    = SLOT_W'((pos_reg - SLOT_W'(1)) >> 1);
    assign left_idx  = CHILD_W'({pos_reg, 1'b1});
    assign right_idx = left_idx + CHILD_W'(1);
    assign left_in   = left_idx < CHILD_W'(fill_reg);
    assign right_in  = right_idx < CHILD_W'(fill_reg);

    assign key_a = rd_data_a[tkh_pkg::KEY_W-1:0];
    assign key_b = rd_data_b[tkh_pkg::KEY_W-1:0];

    // Ties keep the parent, then the left child.
    assign pick_left  = left_in && ($signed(key_a) < $signed(cur_key_reg));
    assign best_key   = pick_left ? key_a : cur_key_reg;
    assign pick_right = right_in && ($signed(key_b) < $signed(best_key));

    assign drain_last = (CNT_W'(pos_reg) + CNT_W'(1)) == fill_reg;

    assign out_key  = key_a;
    assign out_tag  = rd_data_a[ENTRY_W-1:tkh_pkg::KEY_W];
    assign out_slot = pos_reg;
    assign out_last = drain_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkh_pkg::ST_IDLE;
            fill_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_key_reg <= cur_key_next;
        cur_tag_reg <= cur_tag_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        cur_key_next = cur_key_reg;
        cur_tag_next = cur_tag_reg;
        in_ready     = 1'b0;
        out_load     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = {cur_tag_reg, cur_key_reg};
        rd_addr_a    = '0;
        rd_addr_b    = '0;

        unique case (state_reg)
            tkh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_action)
                        tkh_pkg::ACT_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        tkh_pkg::ACT_OFFER:
                        begin
                            cur_key_next = in_key;
                            cur_tag_next = in_tag;
                            if (fill_reg < CNT_W'(HEAP_DEPTH))
                            begin
                                pos_next   = fill_reg[SLOT_W-1:0];
                                fill_next  = fill_reg + CNT_W'(1);
                                state_next = tkh_pkg::ST_UP_RD;
                            end
                            else
                            begin
                                state_next = tkh_pkg::ST_ROOT_RD;
                            end
                        end
                        tkh_pkg::ACT_DRAIN:
                        begin
                            if (fill_reg != '0)
                            begin
                                pos_next   = '0;
                                state_next = tkh_pkg::ST_DR_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Hole walks up: parents larger than the new key move down into it.
            tkh_pkg::ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = tkh_pkg::ST_IDLE;
                end
                else
                begin
                    rd_addr_a  = parent;
                    state_next = tkh_pkg::ST_UP_CMP;
                end
            end

            tkh_pkg::ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if ($signed(key_a) > $signed(cur_key_reg))
                begin
                    wr_data    = rd_data_a;
                    pos_next   = parent;
                    state_next = tkh_pkg::ST_UP_RD;
                end
                else
                begin
                    state_next = tkh_pkg::ST_IDLE;
                end
            end

            tkh_pkg::ST_ROOT_RD:
            begin
                rd_addr_a  = '0;
                state_next = tkh_pkg::ST_ROOT_CMP;
            end

            tkh_pkg::ST_ROOT_CMP:
            begin
                if ($signed(cur_key_reg) > $signed(key_a))
                begin
                    pos_next   = '0;
                    state_next = tkh_pkg::ST_DN_RD;
                end
                else
                begin
                    state_next = tkh_pkg::ST_IDLE;
                end
            end

            // Hole walks down: the smaller child moves up into it.
            tkh_pkg::ST_DN_RD:
            begin
                rd_addr_a  = left_in ? left_idx[SLOT_W-1:0] : '0;
                rd_addr_b  = right_in ? right_idx[SLOT_W-1:0] : '0;
                state_next = tkh_pkg::ST_DN_CMP;
            end

            tkh_pkg::ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (pick_right)
                begin
                    wr_data    = rd_data_b;
                    pos_next   = right_idx[SLOT_W-1:0];
                    state_next = tkh_pkg::ST_DN_RD;
                end
                else if (pick_left)
                begin
                    wr_data    = rd_data_a;
                    pos_next   = left_idx[SLOT_W-1:0];
                    state_next = tkh_pkg::ST_DN_RD;
                end
                else
                begin
                    state_next = tkh_pkg::ST_IDLE;
                end
            end

            tkh_pkg::ST_DR_RD:
            begin
                rd_addr_a  = pos_reg;
                state_next = tkh_pkg::ST_DR_LD;
            end

            // Hold the read address so the entry stays put while the output is blocked.
            tkh_pkg::ST_DR_LD:
            begin
                rd_addr_a = pos_reg;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (drain_last)
                    begin
                        state_next = tkh_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + SLOT_W'(1);
                        state_next = tkh_pkg::ST_DR_RD;
                    end
                end
            end

            default:
            begin
                state_next = tkh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/top_k_min_heap_selector_top.sv
// Top level of the top-K min-heap selector: stream ports, word packing and output register.
`timescale 1ns / 1ps

// Keeps the HEAP_DEPTH largest signed keys offered, each with a tag, in a min-heap held
// in a small RAM with registered reads.
// Input channel s_axis: tuser carries the action (clear, offer, drain), tdata the key
// and tag. Output channel m_axis: one word per occupied slot on a drain, in slot order,
// with tlast on the final word. Clear, offer and unknown actions produce no word, and a
// drain of an empty heap produces none either.
// Timing: a word is taken only while the engine is idle. A clear completes in the cycle
// it is accepted. An offer into a non-full heap climbs the key up L levels (at most 3
// for ten slots), stopping early at the root; an offer into a full heap is either dropped
// after reading the root, or the new root sifts down L levels. Each level is one RAM read
// state followed by one compare-and-write state. A drain reads each word in a read state
// and hands it to the output register in a load state.
// Reset clears the fill count and the controller; the RAM contents need no clearing,
// since only slots below the fill count are ever read.
// When the receiver stalls, the output register holds its word and the drain holds in
// place; the next input word is accepted once the drain has queued its last word.
module top_k_min_heap_selector_top #(
    parameter int HEAP_DEPTH = 10,
    parameter int TAG_BITS   = 10,
    localparam int SLOT_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1,
    localparam int IN_DATA_W   = ((tkh_pkg::KEY_W + TAG_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((tkh_pkg::KEY_W + TAG_BITS + SLOT_W + 7) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_DATA_W-1:0]      s_axis_tdata,   // key, tag (low to high), zero pad
    input  logic [tkh_pkg::ACT_W-1:0] s_axis_tuser,   // action
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_DATA_W-1:0]     m_axis_tdata,   // key_res, tag_res, slot (low to high)
    output logic                      m_axis_tlast    // last
);

    logic                      out_free;
    logic                      out_load;
    logic [tkh_pkg::KEY_W-1:0] eng_key;
    logic [TAG_BITS-1:0]       eng_tag;
    logic [SLOT_W-1:0]         eng_slot;
    logic                      eng_last;

    logic                      out_valid_reg, out_valid_next;
    logic [tkh_pkg::KEY_W-1:0] out_key_reg;
    logic [TAG_BITS-1:0]       out_tag_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic                      out_last_reg;

    tkh_engine #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (tkh_pkg::action_t'(s_axis_tuser)),
        .in_key    (s_axis_tdata[tkh_pkg::KEY_W-1:0]),
        .in_tag    (s_axis_tdata[tkh_pkg::KEY_W +: TAG_BITS]),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_key   (eng_key),
        .out_tag   (eng_tag),
        .out_slot  (eng_slot),
        .out_last  (eng_last)
    );

    // The output register is free when empty or when its word leaves this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_key_reg  <= eng_key;
            out_tag_reg  <= eng_tag;
            out_slot_reg <= eng_slot;
            out_last_reg <= eng_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_slot_reg, out_tag_reg, out_key_reg});
    assign m_axis_tlast  = out_last_reg;

endmodule
